// ===== src/rrd_pkg.sv =====
// Shared codes and types for the RGBE run-length scanline decoder.
// No dependencies; imported by the decoder top level, rrd_cvt and rrd_checker.
`default_nettype none
package rrd_pkg;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_PULL  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PIXEL   = 2'd1,
        KIND_REFUSED = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_UNDET = 2'd0,
        MODE_RLE   = 2'd1,
        MODE_FLAT  = 2'd2,
        MODE_SPARE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_COUNT   = 2'd0,
        PH_RUN     = 2'd1,
        PH_LITERAL = 2'd2,
        PH_HELD    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CFG_LINE_WIDTH = 2'd0,
        CFG_LINE_COUNT = 2'd1,
        CFG_SPARE2     = 2'd2,
        CFG_SPARE3     = 2'd3
    } cfg_idx_t;

    localparam logic [1:0] PLANE_E = 2'd3;
    localparam int unsigned EXP_BIAS_SHIFT = 9;   // 136 bias less mantissa position
    localparam int unsigned SUBN_SHIFT     = 13;

endpackage
`default_nettype wire

// ===== src/rgbe_rle_scanline_decoder.sv =====
// Top level of the RGBE run-length scanline decoder: sequencer and state.
// Depends on rrd_pkg, rrd_store and rrd_cvt.
//
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall   | op, data_byte
//   out     | source    | out_valid/out_stall | kind, *_bits, pixel_x, line_index, last_*
//   cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Steps: a plain data byte or control request is handled in the idle state; a run
// byte is taken, then one plane write follows per copy; a flat quad writes one plane
// per step; a pixel pull makes four store reads through the single read port, and
// the three channels then go through the one converter in turn.
// Reset clears all control state; the plane store is not cleared.
// in_stall is high while a request is in progress or the result register is
// held by out_stall. Config is taken only when the sequencer is idle.
`default_nettype none
module rgbe_rle_scanline_decoder
    import rrd_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [1:0]  kind,
    output logic      [31:0] red_bits,
    output logic      [31:0] green_bits,
    output logic      [31:0] blue_bits,
    output logic      [11:0] pixel_x,
    output logic      [15:0] line_index,
    output logic             last_in_line,
    output logic             last_in_image,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int POS_W  = $clog2(MAX_LINE_WIDTH + 1);
    localparam int DEPTH  = 4 * MAX_LINE_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_QUAD = 7'b0000010,
        ST_RUN  = 7'b0000100,
        ST_PE   = 7'b0001000,
        ST_PR   = 7'b0010000,
        ST_PG   = 7'b0100000,
        ST_PB   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [12:0] lw_reg, lw_next;
    logic [15:0] lc_reg, lc_next;
    logic [23:0] hdr_reg, hdr_next;
    logic [2:0]  hcnt_reg, hcnt_next;
    mode_t       mode_reg, mode_next;
    logic [1:0]  plane_reg, plane_next;
    logic [POS_W-1:0] wpos_reg, wpos_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  rem_reg, rem_next;
    logic [POS_W-1:0] expr_reg, expr_next;
    logic [POS_W-1:0] rpos_reg, rpos_next;
    logic [15:0] line_reg, line_next;
    logic        err_reg, err_next;
    logic [1:0]  q_reg, q_next;
    logic [7:0]  byte_reg, byte_next;
    logic [7:0]  e_reg, e_next;
    logic [31:0] red_reg, red_next;
    logic [31:0] grn_reg, grn_next;
    logic        ov_reg, ov_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] ob_r_reg, ob_r_next, ob_g_reg, ob_g_next, ob_b_reg, ob_b_next;
    logic [11:0] ox_reg, ox_next;
    logic [15:0] oy_reg, oy_next;
    logic        oll_reg, oll_next, oli_reg, oli_next;

    // store ports
    logic              st_we;
    logic [1:0]        st_wplane;
    logic [7:0]        st_wdata;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [1:0]        st_rplane;
    logic [7:0]        st_rdata;
    logic [31:0]       cvt_bits;

    // effective register values
    logic [POS_W-1:0] eff_w;
    logic [15:0]      eff_l;
    logic             done;
    logic             acc;

    // plane-write bookkeeping, shared by literal bytes and run copies
    phase_t           pw_phase_in;
    logic [POS_W-1:0] pw_wp1;
    logic [1:0]       pw_plane;
    logic [POS_W-1:0] pw_wpos, pw_expr;
    phase_t           pw_phase;

    logic [7:0]  cnt_n;
    logic [7:0]  lit_rem;
    mode_t       mode_eff;
    logic        eol;

    function automatic logic [ADDR_W-1:0] st_addr(input logic [1:0] pl,
                                                  input logic [POS_W-1:0] col);
        return ADDR_W'(pl) * ADDR_W'(MAX_LINE_WIDTH) + ADDR_W'(col);
    endfunction

    rrd_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    rrd_cvt u_cvt (
        .mant (st_rdata),
        .expo (e_reg),
        .bits (cvt_bits)
    );

    assign in_stall  = (state_reg != ST_IDLE) || (ov_reg && out_stall);
    assign acc       = in_valid && !in_stall;
    assign cfg_ready = (state_reg == ST_IDLE);

    assign out_valid     = ov_reg;
    assign kind          = kind_reg;
    assign red_bits      = ob_r_reg;
    assign green_bits    = ob_g_reg;
    assign blue_bits     = ob_b_reg;
    assign pixel_x       = ox_reg;
    assign line_index    = oy_reg;
    assign last_in_line  = oll_reg;
    assign last_in_image = oli_reg;

    always_comb
    begin
        if (lw_reg == 13'd0)
        begin
            eff_w = POS_W'(1);
        end
        else if ({3'd0, lw_reg} > 16'(MAX_LINE_WIDTH))
        begin
            eff_w = POS_W'(MAX_LINE_WIDTH);
        end
        else
        begin
            eff_w = POS_W'(lw_reg);
        end
        eff_l = (lc_reg == 16'd0) ? 16'd1 : lc_reg;
    end
    assign done = (line_reg >= eff_l);

    assign lit_rem = rem_reg - 8'd1;
    assign cnt_n   = (data_byte > 8'd128) ? (data_byte - 8'd128) : data_byte;
    assign eol     = ({1'b0, rpos_reg} + 1'b1) >= {1'b0, eff_w};

    always_comb
    begin
        if (mode_reg != MODE_UNDET)
        begin
            mode_eff = mode_reg;
        end
        else if (hdr_reg[23:16] == 8'd2 && hdr_reg[15:8] == 8'd2 && !hdr_reg[7])
        begin
            mode_eff = MODE_RLE;
        end
        else
        begin
            mode_eff = MODE_FLAT;
        end
    end

    // plane write: advance column, close the plane or the line at its end
    always_comb
    begin
        if (state_reg == ST_RUN)
        begin
            pw_phase_in = (rem_reg == 8'd1) ? PH_COUNT : PH_RUN;
        end
        else
        begin
            pw_phase_in = (lit_rem == 8'd0) ? PH_COUNT : PH_LITERAL;
        end
        pw_wp1   = wpos_reg + 1'b1;
        pw_plane = plane_reg;
        pw_wpos  = pw_wp1;
        pw_phase = pw_phase_in;
        pw_expr  = (plane_reg == PLANE_E) ? pw_wp1 : expr_reg;
        if (pw_wp1 >= eff_w && pw_phase_in == PH_COUNT)
        begin
            if (plane_reg == PLANE_E)
            begin
                pw_phase = PH_HELD;
                pw_expr  = eff_w;
            end
            else
            begin
                pw_plane = plane_reg + 2'd1;
                pw_wpos  = '0;
            end
        end
    end

    // store address selection
    always_comb
    begin
        case (state_reg)
            ST_PE:   st_rplane = 2'd0;
            ST_PR:   st_rplane = 2'd1;
            ST_PG:   st_rplane = 2'd2;
            default: st_rplane = PLANE_E;
        endcase
        st_raddr = st_addr(st_rplane, rpos_reg);
        st_waddr = st_addr(st_wplane, wpos_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        lw_next    = lw_reg;
        lc_next    = lc_reg;
        hdr_next   = hdr_reg;
        hcnt_next  = hcnt_reg;
        mode_next  = mode_reg;
        plane_next = plane_reg;
        wpos_next  = wpos_reg;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        expr_next  = expr_reg;
        rpos_next  = rpos_reg;
        line_next  = line_reg;
        err_next   = err_reg;
        q_next     = q_reg;
        byte_next  = byte_reg;
        e_next     = e_reg;
        red_next   = red_reg;
        grn_next   = grn_reg;
        ov_next    = ov_reg && out_stall;
        kind_next  = kind_reg;
        ob_r_next  = ob_r_reg;
        ob_g_next  = ob_g_reg;
        ob_b_next  = ob_b_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oll_next   = oll_reg;
        oli_next   = oli_reg;
        st_we      = 1'b0;
        st_wplane  = plane_reg;
        st_wdata   = data_byte;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LINE_WIDTH: lw_next = cfg_data[12:0];
                CFG_LINE_COUNT: lc_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    // default answer: kind none with clear fields
                    ov_next   = 1'b1;
                    kind_next = KIND_NONE;
                    ob_r_next = '0;
                    ob_g_next = '0;
                    ob_b_next = '0;
                    ox_next   = '0;
                    oy_next   = '0;
                    oll_next  = 1'b0;
                    oli_next  = 1'b0;
                    if (op == OP_START)
                    begin
                        hdr_next   = '0;
                        hcnt_next  = '0;
                        mode_next  = MODE_UNDET;
                        plane_next = '0;
                        wpos_next  = '0;
                        phase_next = PH_COUNT;
                        rem_next   = '0;
                        expr_next  = '0;
                        rpos_next  = '0;
                        line_next  = '0;
                        err_next   = 1'b0;
                    end
                    else if (op == OP_NONE)
                    begin
                        kind_next = KIND_NONE;
                    end
                    else if (err_reg)
                    begin
                        kind_next = KIND_ERROR;
                    end
                    else if (op == OP_PULL)
                    begin
                        if (!done && rpos_reg < expr_reg)
                        begin
                            ov_next    = 1'b0;
                            state_next = ST_PE;
                        end
                    end
                    else if (done)
                    begin
                        kind_next = KIND_NONE;
                    end
                    else if (phase_reg == PH_HELD)
                    begin
                        kind_next = KIND_REFUSED;
                    end
                    else if (mode_reg != MODE_RLE || hcnt_reg < 3'd4)
                    begin
                        // line header or flat quad bytes
                        if (hcnt_reg < 3'd3)
                        begin
                            hdr_next  = {hdr_reg[15:0], data_byte};
                            hcnt_next = hcnt_reg + 3'd1;
                        end
                        else
                        begin
                            mode_next = mode_eff;
                            if (mode_eff == MODE_FLAT)
                            begin
                                st_we      = (wpos_reg < POS_W'(MAX_LINE_WIDTH));
                                st_wplane  = 2'd0;
                                st_wdata   = hdr_reg[23:16];
                                byte_next  = data_byte;
                                q_next     = 2'd1;
                                state_next = ST_QUAD;
                            end
                            else if ({hdr_reg[7:0], data_byte} != 16'(eff_w))
                            begin
                                err_next  = 1'b1;
                                kind_next = KIND_ERROR;
                            end
                            else
                            begin
                                hcnt_next = 3'd4;
                            end
                        end
                    end
                    else if (phase_reg == PH_COUNT)
                    begin
                        if (cnt_n != 8'd0)
                        begin
                            if (17'(wpos_reg) + 17'(cnt_n) > 17'(eff_w))
                            begin
                                err_next  = 1'b1;
                                kind_next = KIND_ERROR;
                            end
                            else
                            begin
                                rem_next   = cnt_n;
                                phase_next = (data_byte > 8'd128) ? PH_RUN : PH_LITERAL;
                            end
                        end
                    end
                    else if (phase_reg == PH_RUN)
                    begin
                        byte_next  = data_byte;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        // literal byte
                        st_we      = (wpos_reg < POS_W'(MAX_LINE_WIDTH));
                        rem_next   = lit_rem;
                        plane_next = pw_plane;
                        wpos_next  = pw_wpos;
                        phase_next = pw_phase;
                        expr_next  = pw_expr;
                    end
                end
            end

            ST_QUAD:
            begin
                st_we     = (wpos_reg < POS_W'(MAX_LINE_WIDTH));
                st_wplane = q_reg;
                case (q_reg)
                    2'd1:    st_wdata = hdr_reg[15:8];
                    2'd2:    st_wdata = hdr_reg[7:0];
                    default: st_wdata = byte_reg;
                endcase
                q_next = q_reg + 2'd1;
                if (q_reg == PLANE_E)
                begin
                    wpos_next  = pw_wp1;
                    expr_next  = pw_wp1;
                    hcnt_next  = '0;
                    if (pw_wp1 >= eff_w)
                    begin
                        phase_next = PH_HELD;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_RUN:
            begin
                // one copy per cycle
                st_we      = (wpos_reg < POS_W'(MAX_LINE_WIDTH));
                st_wdata   = byte_reg;
                rem_next   = rem_reg - 8'd1;
                plane_next = pw_plane;
                wpos_next  = pw_wpos;
                phase_next = pw_phase;
                expr_next  = pw_expr;
                if (rem_reg == 8'd1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PE:
            begin
                e_next     = st_rdata;
                state_next = ST_PR;
            end

            ST_PR:
            begin
                red_next   = cvt_bits;
                state_next = ST_PG;
            end

            ST_PG:
            begin
                grn_next   = cvt_bits;
                state_next = ST_PB;
            end

            ST_PB:
            begin
                ov_next   = 1'b1;
                kind_next = KIND_PIXEL;
                ob_r_next = red_reg;
                ob_g_next = grn_reg;
                ob_b_next = cvt_bits;
                ox_next   = 12'(rpos_reg);
                oy_next   = line_reg;
                oll_next  = eol;
                oli_next  = eol && ((17'(line_reg) + 17'd1) >= 17'(eff_l));
                rpos_next = rpos_reg + 1'b1;
                if (eol)
                begin
                    line_next  = line_reg + 16'd1;
                    rpos_next  = '0;
                    wpos_next  = '0;
                    plane_next = '0;
                    phase_next = PH_COUNT;
                    rem_next   = '0;
                    expr_next  = '0;
                    hcnt_next  = '0;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lw_reg    <= 13'd1;
            lc_reg    <= 16'd1;
            hdr_reg   <= '0;
            hcnt_reg  <= '0;
            mode_reg  <= MODE_UNDET;
            plane_reg <= '0;
            wpos_reg  <= '0;
            phase_reg <= PH_COUNT;
            rem_reg   <= '0;
            expr_reg  <= '0;
            rpos_reg  <= '0;
            line_reg  <= '0;
            err_reg   <= 1'b0;
            q_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lw_reg    <= lw_next;
            lc_reg    <= lc_next;
            hdr_reg   <= hdr_next;
            hcnt_reg  <= hcnt_next;
            mode_reg  <= mode_next;
            plane_reg <= plane_next;
            wpos_reg  <= wpos_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            expr_reg  <= expr_next;
            rpos_reg  <= rpos_next;
            line_reg  <= line_next;
            err_reg   <= err_next;
            q_reg     <= q_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        e_reg    <= e_next;
        red_reg  <= red_next;
        grn_reg  <= grn_next;
        kind_reg <= kind_next;
        ob_r_reg <= ob_r_next;
        ob_g_reg <= ob_g_next;
        ob_b_reg <= ob_b_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oll_reg  <= oll_next;
        oli_reg  <= oli_next;
    end
endmodule
`default_nettype wire

// ===== src/rrd_store.sv =====
// Plane store: one write port, one registered read port.
// Depends on nothing; sized by its parameters.
`default_nettype none
module rrd_store #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/rrd_cvt.sv =====
// Shared channel converter: mantissa byte and exponent byte to float32 bits.
// Uses rrd_pkg constants.
`default_nettype none
module rrd_cvt
    import rrd_pkg::*;
(
    input  wire logic [7:0]  mant,
    input  wire logic [7:0]  expo,
    output logic      [31:0] bits
);
    logic [2:0]  msb;
    logic [8:0]  sum;
    logic [30:0] norm;

    always_comb
    begin
        msb = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (mant[i])
            begin
                msb = 3'(i);
            end
        end
        sum  = 9'(msb) + 9'(expo);
        norm = 31'(mant) << (5'd23 - 5'(msb));
        if (mant == 8'd0)
        begin
            bits = 32'd0;
        end
        else if (sum >= 9'd10)
        begin
            bits = {1'b0, 8'(sum - 9'(EXP_BIAS_SHIFT)), norm[22:0]};
        end
        else
        begin
            // subnormal result
            bits = 32'(mant) << (5'(expo) + 5'(SUBN_SHIFT));
        end
    end
endmodule
`default_nettype wire

// ===== src/rrd_checker.sv =====
// Port-level checks for the decoder, attached by bind.
// Depends on rrd_pkg and on rgbe_rle_scanline_decoder's port names.
`default_nettype none
module rrd_checker
    import rrd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  kind,
    input wire logic [31:0] red_bits,
    input wire logic [31:0] green_bits,
    input wire logic [31:0] blue_bits,
    input wire logic        last_in_line,
    input wire logic        last_in_image
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(red_bits))
        else $error("stalled result changed");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_PIXEL |->
            red_bits == 32'd0 && green_bits == 32'd0 && blue_bits == 32'd0
            && !last_in_line && !last_in_image)
        else $error("non-pixel result carries pixel fields");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_in_image |-> last_in_line)
        else $error("last of image not last of line");
endmodule

bind rgbe_rle_scanline_decoder rrd_checker u_rrd_checker (.*);
`default_nettype wire
